// File: src/ptvt_pkg.sv
// ----------------------------------------------------------------------------
// ptvt_pkg
// Shared types and constants for the PPS time validity tracker.
// ----------------------------------------------------------------------------
package ptvt_pkg;

    // event codes carried in tuser
    typedef enum logic [2:0] {
        ACT_PPS     = 3'd0,
        ACT_FIX_OK  = 3'd1,
        ACT_FIX_BAD = 3'd2,
        ACT_TIMEOUT = 3'd3,
        ACT_GGA     = 3'd4
    } t_action;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_PULSES = 1'b0,
        CFG_WARP   = 1'b1
    } t_cfg_idx;

    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [7:0]  PULSES_RST = 8'd10;
    localparam logic [2:0]  WARP_RST   = 3'd1;

    localparam logic [31:0] US_PER_SEC = 32'd1000000;

    // dispersion = floor(dev * 1024 / 15625)
    // estimate with floor(dev * DISP_RECIP / 2^35), then at most one step up
    localparam int unsigned RECIP_SHIFT = 35;
    localparam logic [31:0] DISP_RECIP  = 32'd2251799813;
    localparam logic [13:0] DISP_DEN    = 14'd15625;
    localparam int unsigned QUOT_W      = 64 - RECIP_SHIFT;

    // one input item, without the event code
    typedef struct packed {
        logic [3:0]  fix_kind;
        logic [5:0]  satellites;
        logic [31:0] gps_seconds;
        logic [31:0] timestamp_us;
    } t_item;

    // status snapshot after one item (dispersion added downstream)
    typedef struct packed {
        logic [3:0]  fix_seen;
        logic [5:0]  sat_seen;
        logic [31:0] first_valid_sec;
        logic [31:0] valid_since_sec;
        logic [31:0] valid_total;
        logic [31:0] timeout_total;
        logic [31:0] max_interval_us;
        logic [31:0] min_interval_us;
        logic [31:0] second_count;
        logic        fix_valid;
        logic        time_valid;
    } t_status;

endpackage

// File: src/ptvt_state.sv
// ----------------------------------------------------------------------------
// ptvt_state
// Tracker state and its registered update; the state registers double as
// the stage payload handed to the dispersion pipeline.
// ----------------------------------------------------------------------------
module ptvt_state
    import ptvt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_valid,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // item from the input register
    input  logic                  i_up_valid,
    output logic                  o_up_ready,
    input  t_action               i_up_action,
    input  t_item                 i_up_item,
    // status towards the dispersion pipeline
    output logic                  o_dn_valid,
    input  logic                  i_dn_ready,
    output t_status               o_dn_status
);

    logic [7:0]  r_pulses_needed;
    logic [2:0]  r_warp_limit;

    logic        r_v;
    logic [31:0] r_sec, n_sec;
    logic [31:0] r_prev, n_prev;
    logic        r_have_prev, n_have_prev;
    logic [31:0] r_min, n_min;
    logic [31:0] r_max, n_max;
    logic        r_valid, n_valid;
    logic        r_fix, n_fix;
    logic [7:0]  r_cd, n_cd;
    logic [2:0]  r_warp, n_warp;
    logic [31:0] r_since, n_since;
    logic [31:0] r_vcnt, n_vcnt;
    logic [31:0] r_first, n_first;
    logic [31:0] r_tocnt, n_tocnt;
    logic [5:0]  r_sat, n_sat;
    logic [3:0]  r_fixq, n_fixq;

    logic        w_take;

    assign o_up_ready = !r_v || i_dn_ready;
    assign w_take     = i_up_valid && o_up_ready;

    always_comb begin
        logic [31:0] iv;
        logic [3:0]  warp_inc;
        iv       = i_up_item.timestamp_us - r_prev;
        warp_inc = {1'b0, r_warp} + 4'd1;

        n_sec       = r_sec;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_min       = r_min;
        n_max       = r_max;
        n_valid     = r_valid;
        n_fix       = r_fix;
        n_cd        = r_cd;
        n_warp      = r_warp;
        n_since     = r_since;
        n_vcnt      = r_vcnt;
        n_first     = r_first;
        n_tocnt     = r_tocnt;
        n_sat       = r_sat;
        n_fixq      = r_fixq;

        case (i_up_action)
            ACT_PPS: begin
                if (r_fix) begin
                    if (r_cd != 8'd0) begin
                        n_cd = r_cd - 8'd1;
                        if (n_cd == 8'd0) begin
                            n_min   = '0;
                            n_max   = '0;
                            n_valid = 1'b1;
                            n_since = r_sec;
                            n_vcnt  = r_vcnt + 32'd1;
                            if (r_first == 32'd0) begin
                                n_first = r_sec;
                            end
                        end
                    end
                    n_sec  = r_sec + 32'd1;
                    n_prev = i_up_item.timestamp_us;
                    if (!r_have_prev) begin
                        n_have_prev = 1'b1;
                    end else begin
                        if (n_min == 32'd0 || iv < n_min) begin
                            n_min = iv;
                        end
                        if (iv > n_max) begin
                            n_max = iv;
                        end
                    end
                end
            end
            ACT_FIX_OK: begin
                if (r_valid && r_sec > i_up_item.gps_seconds) begin
                    // backward warp
                    if (warp_inc > {1'b0, r_warp_limit}) begin
                        n_since     = r_sec;
                        n_valid     = 1'b0;
                        n_fix       = 1'b0;
                        n_have_prev = 1'b0;
                        n_cd        = '0;
                        n_warp      = '0;
                    end else begin
                        n_warp = warp_inc[2:0];
                    end
                end else if (r_sec != i_up_item.gps_seconds) begin
                    n_sec = i_up_item.gps_seconds;
                end else begin
                    n_warp = '0;
                end
                if (!n_fix) begin
                    n_fix = 1'b1;
                    n_cd  = r_pulses_needed;
                end
            end
            ACT_FIX_BAD: begin
                if (r_valid) begin
                    n_since     = r_sec;
                    n_valid     = 1'b0;
                    n_fix       = 1'b0;
                    n_have_prev = 1'b0;
                    n_cd        = '0;
                end
            end
            ACT_TIMEOUT: begin
                if (r_first != 32'd0) begin
                    n_tocnt = r_tocnt + 32'd1;
                end
                if (r_valid) begin
                    n_since = r_sec;
                end
                n_valid     = 1'b0;
                n_fix       = 1'b0;
                n_have_prev = 1'b0;
                n_cd        = '0;
            end
            ACT_GGA: begin
                n_sat  = i_up_item.satellites;
                n_fixq = i_up_item.fix_kind;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulses_needed <= PULSES_RST;
            r_warp_limit    <= WARP_RST;
            r_v             <= 1'b0;
            r_sec           <= '0;
            r_prev          <= '0;
            r_have_prev     <= 1'b0;
            r_min           <= '0;
            r_max           <= '0;
            r_valid         <= 1'b0;
            r_fix           <= 1'b0;
            r_cd            <= '0;
            r_warp          <= '0;
            r_since         <= '0;
            r_vcnt          <= '0;
            r_first         <= '0;
            r_tocnt         <= '0;
            r_sat           <= '0;
            r_fixq          <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PULSES: r_pulses_needed <= i_cfg_data[7:0];
                    CFG_WARP:   r_warp_limit    <= i_cfg_data[2:0];
                endcase
            end
            if (o_up_ready) begin
                r_v <= i_up_valid;
            end
            if (w_take) begin
                r_sec       <= n_sec;
                r_prev      <= n_prev;
                r_have_prev <= n_have_prev;
                r_min       <= n_min;
                r_max       <= n_max;
                r_valid     <= n_valid;
                r_fix       <= n_fix;
                r_cd        <= n_cd;
                r_warp      <= n_warp;
                r_since     <= n_since;
                r_vcnt      <= n_vcnt;
                r_first     <= n_first;
                r_tocnt     <= n_tocnt;
                r_sat       <= n_sat;
                r_fixq      <= n_fixq;
            end
        end
    end

    assign o_dn_valid                  = r_v;
    assign o_dn_status.time_valid      = r_valid;
    assign o_dn_status.fix_valid       = r_fix;
    assign o_dn_status.second_count    = r_sec;
    assign o_dn_status.min_interval_us = r_min;
    assign o_dn_status.max_interval_us = r_max;
    assign o_dn_status.timeout_total   = r_tocnt;
    assign o_dn_status.valid_total     = r_vcnt;
    assign o_dn_status.valid_since_sec = r_since;
    assign o_dn_status.first_valid_sec = r_first;
    assign o_dn_status.sat_seen        = r_sat;
    assign o_dn_status.fix_seen        = r_fixq;

endmodule

// File: src/ptvt_disp.sv
// ----------------------------------------------------------------------------
// ptvt_disp
// Dispersion pipeline: deviations, worst deviation, reciprocal multiply,
// back-multiply and one-step correction. Status rides alongside.
// ----------------------------------------------------------------------------
module ptvt_disp
    import ptvt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_up_valid,
    output logic        o_up_ready,
    input  t_status     i_up_status,
    output logic        o_dn_valid,
    input  logic        i_dn_ready,
    output t_status     o_dn_status,
    output logic [31:0] o_dn_dispersion
);

    logic              r2_v, r3_v, r4_v, r5_v, r6_v;
    logic              w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy6;
    t_status           r2_st, r3_st, r4_st, r5_st, r6_st;
    logic [31:0]       r2_dev_a, r2_dev_b;
    logic [31:0]       r3_dev, r4_dev, r5_dev;
    logic [63:0]       r4_prod;
    logic [QUOT_W-1:0] r5_qest;
    logic [QUOT_W+13:0] r5_back;
    logic [31:0]       r6_disp;

    logic [31:0]       w_dev_a, w_dev_b;
    logic [QUOT_W-1:0] w_qest;
    logic [41:0]       w_rem;
    logic [QUOT_W-1:0] w_quot;

    assign w_rdy6     = !r6_v || i_dn_ready;
    assign w_rdy5     = !r5_v || w_rdy6;
    assign w_rdy4     = !r4_v || w_rdy5;
    assign w_rdy3     = !r3_v || w_rdy4;
    assign w_rdy2     = !r2_v || w_rdy3;
    assign o_up_ready = w_rdy2;

    assign w_dev_a = (i_up_status.max_interval_us >= US_PER_SEC)
                   ? i_up_status.max_interval_us - US_PER_SEC
                   : US_PER_SEC - i_up_status.max_interval_us;
    assign w_dev_b = (i_up_status.min_interval_us >= US_PER_SEC)
                   ? i_up_status.min_interval_us - US_PER_SEC
                   : US_PER_SEC - i_up_status.min_interval_us;

    assign w_qest = r4_prod[63:RECIP_SHIFT];
    // remainder of dev * 1024 against the estimate; below twice the divisor
    assign w_rem  = {r5_dev, 10'b0} - 42'(r5_back);
    assign w_quot = (w_rem >= 42'(DISP_DEN)) ? r5_qest + 1'b1 : r5_qest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            if (w_rdy2) r2_v <= i_up_valid;
            if (w_rdy3) r3_v <= r2_v;
            if (w_rdy4) r4_v <= r3_v;
            if (w_rdy5) r5_v <= r4_v;
            if (w_rdy6) r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_st    <= i_up_status;
            r2_dev_a <= w_dev_a;
            r2_dev_b <= w_dev_b;
        end
        if (w_rdy3) begin
            r3_st  <= r2_st;
            r3_dev <= (r2_dev_a > r2_dev_b) ? r2_dev_a : r2_dev_b;
        end
        if (w_rdy4) begin
            r4_st   <= r3_st;
            r4_dev  <= r3_dev;
            r4_prod <= 64'(r3_dev) * 64'(DISP_RECIP);
        end
        if (w_rdy5) begin
            r5_st   <= r4_st;
            r5_dev  <= r4_dev;
            r5_qest <= w_qest;
            r5_back <= (QUOT_W+14)'(w_qest) * (QUOT_W+14)'(DISP_DEN);
        end
        if (w_rdy6) begin
            r6_st   <= r5_st;
            r6_disp <= 32'(w_quot);
        end
    end

    assign o_dn_valid      = r6_v;
    assign o_dn_status     = r6_st;
    assign o_dn_dispersion = r6_disp;

endmodule

// File: src/pps_time_validity_tracker_core.sv
// ----------------------------------------------------------------------------
// pps_time_validity_tracker_core
// Decides whether a GPS-disciplined seconds clock can be trusted from PPS,
// RMC, timeout and GGA events, and emits one status beat per event.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  -----------------------------------
//  s_axis   in   s_axis_tvalid/tready   tuser: event code; tdata: event data
//  m_axis   out  m_axis_tvalid/tready   tdata: status after the event
//  cfg      in   i_cfg_valid/o_cfg_ready index 0 pulses needed, 1 warp limit
//
//  One event is taken per clock unless m_axis stalls long enough to fill every
//  stage; every event yields exactly one status beat, presented on m_axis
//  after the input register (loaded on the accepting edge), the state update
//  and five dispersion stages. The dispersion divide by 15625 is a 32x32
//  reciprocal multiply followed by a back-multiply and a single correction step.
//  Reset is synchronous, active low; it restores pulses needed to 10 and
//  the warp limit to 1 and clears all tracker state. No clearing pass.
//  Stalls on m_axis fill the stage registers from the output backwards;
//  s_axis_tready only drops once every stage holds a beat.
//  Configuration writes are always accepted and take effect next cycle.
//
module pps_time_validity_tracker_core
    import ptvt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // event stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] timestamp_us, [63:32] gps_seconds, [69:64] satellites,
    // [73:70] fix_kind, [79:74] zero
    input  logic [79:0]           s_axis_tdata,
    // [2:0] action
    input  logic [2:0]            s_axis_tuser,
    // status stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] time_valid, [1] fix_valid, [33:2] second_count,
    // [65:34] min_interval_us, [97:66] max_interval_us, [129:98] dispersion,
    // [161:130] timeout_total, [193:162] valid_total,
    // [225:194] valid_since_sec, [257:226] first_valid_sec,
    // [263:258] sat_seen, [267:264] fix_seen, [271:268] zero
    output logic [271:0]          m_axis_tdata
);

    // input register
    logic    r_in_v;
    t_action r_in_action;
    t_item   r_in_item;

    logic    w_st_valid, w_st_ready, w_up_ready;
    t_status w_st;
    t_status w_out_st;
    logic [31:0] w_out_disp;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_in_v || w_up_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_action <= t_action'(s_axis_tuser);
            r_in_item   <= s_axis_tdata[73:0];
        end
    end

    ptvt_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_up_valid  (r_in_v),
        .o_up_ready  (w_up_ready),
        .i_up_action (r_in_action),
        .i_up_item   (r_in_item),
        .o_dn_valid  (w_st_valid),
        .i_dn_ready  (w_st_ready),
        .o_dn_status (w_st)
    );

    ptvt_disp u_disp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_up_valid      (w_st_valid),
        .o_up_ready      (w_st_ready),
        .i_up_status     (w_st),
        .o_dn_valid      (m_axis_tvalid),
        .i_dn_ready      (m_axis_tready),
        .o_dn_status     (w_out_st),
        .o_dn_dispersion (w_out_disp)
    );

    assign m_axis_tdata = {
        4'b0,
        w_out_st.fix_seen,
        w_out_st.sat_seen,
        w_out_st.first_valid_sec,
        w_out_st.valid_since_sec,
        w_out_st.valid_total,
        w_out_st.timeout_total,
        w_out_disp,
        w_out_st.max_interval_us,
        w_out_st.min_interval_us,
        w_out_st.second_count,
        w_out_st.fix_valid,
        w_out_st.time_valid
    };

    // ---- assertions ----

    // trusted time always implies a held fix
    a_valid_needs_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_st.time_valid |-> w_st.fix_valid)
        else $error("time valid without fix");

    // a recorded minimum never exceeds the maximum
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_st.min_interval_us <= w_st.max_interval_us)
        else $error("min interval above max interval");

    // deviation below 2^32 us keeps the 16.16 result under 2^29
    a_disp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_out_disp[31:29] == 3'b000))
        else $error("dispersion out of range");

    // a state update only happens when the input register hands over a beat
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_v && w_up_ready) |=> $stable(w_st))
        else $error("state changed without an event");

endmodule

// File: dv/ptvt_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptvt_status_checker
// Watches the config, event and status channels of the tracker, keeps its own
// copy of the tracker state, and compares every status beat with the beat
// predicted for the oldest outstanding event.
// ----------------------------------------------------------------------------
module ptvt_status_checker
    import ptvt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_evt_valid,
    input  logic                  i_evt_ready,
    input  logic [79:0]           i_evt_data,
    input  logic [2:0]            i_evt_user,
    input  logic                  i_sts_valid,
    input  logic                  i_sts_ready,
    input  logic [271:0]          i_sts_data,
    output int                    o_mismatches,
    output int                    o_pending
);

    // status beat as laid out on m_axis_tdata, msb first
    typedef struct packed {
        logic [3:0]  pad;
        logic [3:0]  fix_seen;
        logic [5:0]  sat_seen;
        logic [31:0] first_valid_sec;
        logic [31:0] valid_since_sec;
        logic [31:0] valid_total;
        logic [31:0] timeout_total;
        logic [31:0] dispersion;
        logic [31:0] max_interval_us;
        logic [31:0] min_interval_us;
        logic [31:0] second_count;
        logic        fix_valid;
        logic        time_valid;
    } t_status_beat;

    // shadow configuration
    logic [7:0]  need_pulses;
    logic [2:0]  warp_cap;

    // shadow tracker state
    logic [31:0] secs, last_stamp, iv_min, iv_max;
    logic        stamp_held, trusted, fix_ok;
    logic [7:0]  pulses_left;
    logic [2:0]  warps;
    logic [31:0] since_sec, trust_count, first_trust_sec, timeouts;
    logic [5:0]  sats;
    logic [3:0]  fixq;

    t_status_beat status_due[$];
    int           mismatch_n;
    int           beat_n;

    assign o_mismatches = mismatch_n;

    function automatic logic [63:0] offset_from_second(input logic [31:0] iv);
        return (iv >= US_PER_SEC) ? 64'(iv - US_PER_SEC) : 64'(US_PER_SEC - iv);
    endfunction

    // worst deviation in 16.16 seconds, saturating
    function automatic logic [31:0] dispersion_of(input logic [31:0] lo, input logic [31:0] hi);
        logic [63:0] dev_lo, dev_hi, worst, q;
        dev_lo = offset_from_second(lo);
        dev_hi = offset_from_second(hi);
        worst  = (dev_hi > dev_lo) ? dev_hi : dev_lo;
        q      = (worst * 64'd65536) / 64'(US_PER_SEC);
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    task automatic lose_trust();
        if (trusted)
            since_sec = secs;
        trusted     = 1'b0;
        fix_ok      = 1'b0;
        stamp_held  = 1'b0;
        pulses_left = 8'd0;
    endtask

    task automatic track_event(input logic [2:0] act, input logic [79:0] raw);
        t_item       ev;
        logic [31:0] iv;
        logic [3:0]  nwarp;
        ev = t_item'(raw[73:0]);
        case (act)
            ACT_PPS: begin
                if (fix_ok) begin
                    if (pulses_left != 8'd0) begin
                        pulses_left = pulses_left - 8'd1;
                        if (pulses_left == 8'd0) begin
                            iv_min      = '0;
                            iv_max      = '0;
                            trusted     = 1'b1;
                            since_sec   = secs;
                            trust_count = trust_count + 32'd1;
                            if (first_trust_sec == '0)
                                first_trust_sec = secs;
                        end
                    end
                    secs = secs + 32'd1;
                    if (!stamp_held) begin
                        // first pulse after a loss only latches the stamp
                        last_stamp = ev.timestamp_us;
                        stamp_held = 1'b1;
                    end else begin
                        iv         = ev.timestamp_us - last_stamp;
                        last_stamp = ev.timestamp_us;
                        if (iv_min == '0 || iv < iv_min)
                            iv_min = iv;
                        if (iv > iv_max)
                            iv_max = iv;
                    end
                end
            end
            ACT_FIX_OK: begin
                if (trusted && secs > ev.gps_seconds) begin
                    // backward warp: seconds left alone
                    nwarp = {1'b0, warps} + 4'd1;
                    if (nwarp > {1'b0, warp_cap}) begin
                        lose_trust();
                        warps = 3'd0;
                    end else begin
                        warps = nwarp[2:0];
                    end
                end else if (secs != ev.gps_seconds) begin
                    secs = ev.gps_seconds;
                end else begin
                    warps = 3'd0;
                end
                if (!fix_ok) begin
                    fix_ok      = 1'b1;
                    pulses_left = need_pulses;
                end
            end
            ACT_FIX_BAD: begin
                if (trusted)
                    lose_trust();
            end
            ACT_TIMEOUT: begin
                if (first_trust_sec != '0)
                    timeouts = timeouts + 32'd1;
                lose_trust();
            end
            ACT_GGA: begin
                sats = ev.satellites;
                fixq = ev.fix_kind;
            end
            default: ;
        endcase
    endtask

    function automatic t_status_beat status_now();
        t_status_beat b;
        b.pad             = '0;
        b.fix_seen        = fixq;
        b.sat_seen        = sats;
        b.first_valid_sec = first_trust_sec;
        b.valid_since_sec = since_sec;
        b.valid_total     = trust_count;
        b.timeout_total   = timeouts;
        b.dispersion      = dispersion_of(iv_min, iv_max);
        b.max_interval_us = iv_max;
        b.min_interval_us = iv_min;
        b.second_count    = secs;
        b.fix_valid       = fix_ok;
        b.time_valid      = trusted;
        return b;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_n++;
            if (mismatch_n <= 10)
                $display("%0t status beat %0d: %s expected 0x%08h, got 0x%08h",
                         $time, beat_n, what, want, got);
        end
    endtask

    task automatic check_beat(input t_status_beat got);
        t_status_beat want;
        if (status_due.size() == 0) begin
            mismatch_n++;
            if (mismatch_n <= 10)
                $display("%0t status beat %0d with no event outstanding", $time, beat_n);
        end else begin
            want = status_due.pop_front();
            check_field("time_valid",      32'(want.time_valid),  32'(got.time_valid));
            check_field("fix_valid",       32'(want.fix_valid),   32'(got.fix_valid));
            check_field("second_count",    want.second_count,     got.second_count);
            check_field("min_interval_us", want.min_interval_us,  got.min_interval_us);
            check_field("max_interval_us", want.max_interval_us,  got.max_interval_us);
            check_field("dispersion",      want.dispersion,       got.dispersion);
            check_field("timeout_total",   want.timeout_total,    got.timeout_total);
            check_field("valid_total",     want.valid_total,      got.valid_total);
            check_field("valid_since_sec", want.valid_since_sec,  got.valid_since_sec);
            check_field("first_valid_sec", want.first_valid_sec,  got.first_valid_sec);
            check_field("sat_seen",        32'(want.sat_seen),    32'(got.sat_seen));
            check_field("fix_seen",        32'(want.fix_seen),    32'(got.fix_seen));
        end
        beat_n++;
    endtask

    initial begin
        mismatch_n = 0;
        beat_n     = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            need_pulses     = PULSES_RST;
            warp_cap        = WARP_RST;
            secs            = '0;
            last_stamp      = '0;
            iv_min          = '0;
            iv_max          = '0;
            stamp_held      = 1'b0;
            trusted         = 1'b0;
            fix_ok          = 1'b0;
            pulses_left     = '0;
            warps           = '0;
            since_sec       = '0;
            trust_count     = '0;
            first_trust_sec = '0;
            timeouts        = '0;
            sats            = '0;
            fixq            = '0;
            status_due.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_PULSES)
                    need_pulses = i_cfg_data[7:0];
                else
                    warp_cap = i_cfg_data[2:0];
            end
            if (i_evt_valid && i_evt_ready) begin
                track_event(i_evt_user, i_evt_data);
                status_due.push_back(status_now());
            end
            if (i_sts_valid && i_sts_ready)
                check_beat(t_status_beat'(i_sts_data));
            o_pending <= status_due.size();
        end
    end

endmodule

// File: dv/tb_pps_time_validity_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pps_time_validity_tracker_core
// Drives PPS, RMC, timeout and GGA events into the tracker under several
// configurations and back-pressure mixes; a checker alongside predicts and
// compares every status beat.
// ----------------------------------------------------------------------------
module tb_pps_time_validity_tracker_core;
    import ptvt_pkg::*;

    // longest legitimate quiet spell is the forced receiver hold
    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_LEN    = 80;
    // status beat leaves after the input, state and dispersion registers; allow margin
    localparam int DRAIN_PAUSE = 16;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [79:0]           s_axis_tdata;   // ts[31:0], gps s[63:32], sats[69:64], fixq[73:70]
    logic [2:0]            s_axis_tuser;   // action[2:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [271:0]          m_axis_tdata;

    int mismatches;
    int pending;

    // stimulus knobs, changed only between phases
    int snd_idle_pct;
    int rcv_stall_pct;
    int noise_pct;
    int need_now;

    // forced receiver hold: sender asks, receiver process serves
    int hold_asked;
    int hold_seen;
    int hold_left;

    // stimulus-side guesses of the pulse clock and the seconds count
    logic [31:0] ts_now;
    logic [31:0] sec_guess;
    int          sent_items;

    int quiet;

    pps_time_validity_tracker_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ptvt_status_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_evt_valid  (s_axis_tvalid),
        .i_evt_ready  (s_axis_tready),
        .i_evt_data   (s_axis_tdata),
        .i_evt_user   (s_axis_tuser),
        .i_sts_valid  (m_axis_tvalid),
        .i_sts_ready  (m_axis_tready),
        .i_sts_data   (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- sender
    // one event beat; valid is left high after the handshake so back-to-back
    // beats never see it dropped and raised in the same step
    task automatic send_event(input logic [2:0] act, input logic [31:0] ts,
                              input logic [31:0] gs, input logic [5:0] sats,
                              input logic [3:0] fixk);
        t_item ev;
        ev.timestamp_us = ts;
        ev.gps_seconds  = gs;
        ev.satellites   = sats;
        ev.fix_kind     = fixk;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = {6'd0, ev};
        s_axis_tuser  = act;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
    endtask

    // PPS about a second apart with up to 200 us of jitter, the odd wild stamp or repeated stamp
    task automatic send_pulse();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            ts_now = $urandom();
        else if (r >= 5)
            ts_now = ts_now + US_PER_SEC + $urandom_range(0, 400) - 200;
        sec_guess = sec_guess + 32'd1;
        send_event(ACT_PPS, ts_now, $urandom(), 6'($urandom()), 4'($urandom()));
    endtask

    task automatic send_fix(input logic [31:0] gs);
        send_event(ACT_FIX_OK, $urandom(), gs, 6'($urandom()), 4'($urandom()));
    endtask

    task automatic send_noise();
        send_event(3'($urandom_range(0, 7)), $urandom(), $urandom(),
                   6'($urandom()), 4'($urandom()));
    endtask

    task automatic send_gga();
        send_event(ACT_GGA, $urandom(), $urandom(), 6'($urandom()), 4'($urandom()));
    endtask

    // fix, a run long enough to reach validity, then most often an attempt at losing it
    task automatic run_episode();
        int steps;
        int k;
        int r;
        if ($urandom_range(0, 9) < 3)
            sec_guess = $urandom();
        else
            sec_guess = sec_guess + $urandom_range(0, 3);
        send_fix(sec_guess);
        steps = need_now + need_now / 4 + $urandom_range(4, 12);
        for (k = 0; k < steps; k++) begin
            r = $urandom_range(0, 99);
            if (r < noise_pct)
                send_noise();
            else if (r < 86)
                send_pulse();
            else if (r < 91)
                send_fix(sec_guess);
            else if (r < 95)
                send_fix(sec_guess - $urandom_range(1, 4));
            else
                send_gga();
        end
        case ($urandom_range(0, 3))
            0: send_event(ACT_TIMEOUT, $urandom(), $urandom(), 6'($urandom()), 4'($urandom()));
            1: send_event(ACT_FIX_BAD, $urandom(), $urandom(), 6'($urandom()), 4'($urandom()));
            2: begin
                send_fix(sec_guess - 32'd2);
                send_fix(sec_guess - 32'd3);
            end
            default: ;
        endcase
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // every event yields a beat, so an empty scoreboard means the core is idle
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int pulses, input int warp, input int snd_pct,
                             input int rcv_pct, input int noise, input int budget,
                             input bit squeeze);
        int start_n;
        wait_drained();
        write_reg(CFG_PULSES, 8'(pulses));
        write_reg(CFG_WARP, 8'(warp));
        need_now      = pulses;
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        noise_pct     = noise;
        if (squeeze)
            hold_asked++;
        start_n = sent_items;
        while (sent_items - start_n < budget)
            run_episode();
    endtask

    // -------------------------------------------------------------- receiver
    initial begin
        m_axis_tready = 1'b0;
        hold_seen     = 0;
        hold_left     = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else if (hold_seen != hold_asked) begin
                // long hold: pipeline fills and s_axis_tready must fall
                hold_seen++;
                hold_left     = HOLD_LEN - 1;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = ($urandom_range(0, 99) >= rcv_stall_pct);
            end
        end
    end

    // -------------------------------------------------------------- watchdog
    initial begin
        quiet = 0;
        @(posedge i_rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL pps_time_validity_tracker_core");
        $finish;
    end

    // ------------------------------------------------------------- main flow
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_PULSES;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        noise_pct     = 4;
        need_now      = PULSES_RST;
        hold_asked    = 0;
        sent_items    = 0;
        ts_now        = 32'hFFFF_FFFF - 32'd3_500_000;   // wraps mid-run
        sec_guess     = 32'hFFFF_FFF8;                   // seconds wrap too

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset config (10 pulses, one warp tolerated)
        send_event(ACT_GGA, '1, '1, 6'h3F, 4'hF);
        send_event(ACT_GGA, '0, '0, 6'h00, 4'h0);
        send_event(3'd5, '1, '1, 6'h3F, 4'hF);           // unused codes
        send_event(3'd6, '1, '1, 6'h3F, 4'hF);
        send_event(3'd7, '1, '1, 6'h3F, 4'hF);
        send_event(ACT_PPS, 32'd123, '0, '0, '0);        // pulse with no fix
        send_event(ACT_FIX_BAD, '0, '0, '0, '0);         // while not valid
        send_event(ACT_TIMEOUT, '0, '0, '0, '0);         // before first valid
        send_fix(sec_guess);
        repeat (10) begin
            ts_now    = ts_now + US_PER_SEC + $urandom_range(0, 40) - 20;
            sec_guess = sec_guess + 32'd1;
            send_event(ACT_PPS, ts_now, '0, '0, '0);
        end
        sec_guess = sec_guess + 32'd1;
        send_event(ACT_PPS, ts_now, '0, '0, '0);         // zero interval
        ts_now    = ts_now - 32'd1;
        sec_guess = sec_guess + 32'd1;
        send_event(ACT_PPS, ts_now, '0, '0, '0);         // largest interval
        send_fix(sec_guess - 32'd3);                     // warp, tolerated
        send_fix(sec_guess);                             // agrees, warps cleared
        send_fix(sec_guess - 32'd1);
        send_fix(sec_guess - 32'd2);                     // over the limit
        send_event(ACT_TIMEOUT, '0, '0, '0, '0);         // counted now
        sec_guess = sec_guess + 32'd5;
        send_fix(sec_guess);                             // forward jump

        // random phases: pulses, warp, sender idle %, receiver stall %, noise %, budget, squeeze
        run_phase(1,   0, 0,  0,  4, 40,  1'b1);
        run_phase(4,   7, 49, 0,  4, 40,  1'b0);
        run_phase(0,   3, 0,  49, 4, 40,  1'b0);         // never validates
        run_phase(150, 2, 16, 16, 0, 150, 1'b0);
        run_phase(10,  5, 16, 16, 4, 40,  1'b0);

        wait_drained();
        repeat (DRAIN_PAUSE) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS pps_time_validity_tracker_core");
        else
            $display("FAIL pps_time_validity_tracker_core");
        $finish;
    end

endmodule
